// ===== src/ghma_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the gated heading moving average.
// Used by ghma_ctrl, ghma_datapath and the top level; depends on nothing.

package ghma_pkg;

    // Window geometry. The average is taken with a right shift, so the
    // window length must stay a power of two.
    localparam int WINDOW_LEN = 8;
    localparam int IDX_W      = $clog2(WINDOW_LEN);
    localparam int HEAD_W     = 9;
    localparam int SUM_W      = HEAD_W + IDX_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPREAD_LIMIT = 2'd0,
        REG_BAND_LOW     = 2'd1,
        REG_BAND_HIGH    = 2'd2
    } cfg_reg_t;

    // Register values after reset.
    localparam logic [HEAD_W-1:0] SPREAD_LIMIT_RST = 9'd6;
    localparam logic [HEAD_W-1:0] BAND_LOW_RST     = 9'd10;
    localparam logic [HEAD_W-1:0] BAND_HIGH_RST    = 9'd350;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // take the new heading and restart the accumulators
        logic scan;      // fold one window entry into sum, max and min
        logic load_out;  // form the result and load the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last; // the entry being folded in is the last one
    } status_t;

endpackage

// ===== src/ghma_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the gated heading moving average.
// Depends on ghma_pkg; drives the commands of ghma_datapath.

module ghma_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  ghma_pkg::status_t status,
    output ghma_pkg::cmd_t    cmd
);

    ghma_pkg::state_t state_reg;
    ghma_pkg::state_t state_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic             out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ghma_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ghma_pkg::ST_SCAN;
                end
            end
            ghma_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ghma_pkg::ST_FINISH;
                end
            end
            ghma_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ghma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ghma_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.scan     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ghma_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ghma_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ghma_pkg::ST_FINISH:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ghma_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== src/ghma_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the gated heading moving average: window, accumulators,
// configuration registers and output register. Depends on ghma_pkg.

module ghma_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ghma_pkg::HEAD_W-1:0]      heading,
    input  logic                             cfg_wr_en,
    input  logic [ghma_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ghma_pkg::HEAD_W-1:0]      cfg_data,
    input  ghma_pkg::cmd_t                   cmd,
    output ghma_pkg::status_t                status,
    output logic [ghma_pkg::HEAD_W-1:0]      smoothed_heading,
    output logic                             was_averaged
);

    logic [ghma_pkg::HEAD_W-1:0] window_reg [ghma_pkg::WINDOW_LEN];
    logic [ghma_pkg::IDX_W-1:0]  wp_reg;
    logic [ghma_pkg::IDX_W-1:0]  wp_next;
    logic [ghma_pkg::IDX_W-1:0]  cnt_reg;
    logic [ghma_pkg::SUM_W-1:0]  sum_reg;
    logic [ghma_pkg::HEAD_W-1:0] hi_reg;
    logic [ghma_pkg::HEAD_W-1:0] lo_reg;
    logic [ghma_pkg::HEAD_W-1:0] head_reg;
    logic [ghma_pkg::HEAD_W-1:0] spread_reg;
    logic [ghma_pkg::HEAD_W-1:0] band_low_reg;
    logic [ghma_pkg::HEAD_W-1:0] band_high_reg;
    logic [ghma_pkg::HEAD_W-1:0] out_head_reg;
    logic                        out_avg_reg;

    logic [ghma_pkg::HEAD_W-1:0] entry;
    logic [ghma_pkg::HEAD_W:0]   lo_plus_spread;
    logic [ghma_pkg::HEAD_W-1:0] average;
    logic                        gate;

    localparam logic [ghma_pkg::IDX_W-1:0] LAST_IDX =
        ghma_pkg::IDX_W'(ghma_pkg::WINDOW_LEN - 1);

    assign entry = window_reg[cnt_reg];
    assign status.scan_last = (cnt_reg == LAST_IDX);
    assign wp_next = (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;

    // Gate: narrow spread and the new heading inside the inclusive band.
    assign lo_plus_spread = {1'b0, lo_reg} + {1'b0, spread_reg};
    assign gate = ({1'b0, hi_reg} < lo_plus_spread)
                  && (head_reg >= band_low_reg)
                  && (head_reg <= band_high_reg);
    assign average = sum_reg[ghma_pkg::SUM_W-1:ghma_pkg::IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ghma_pkg::WINDOW_LEN; k++)
            begin
                window_reg[k] <= '0;
            end
            wp_reg        <= '0;
            cnt_reg       <= '0;
            spread_reg    <= ghma_pkg::SPREAD_LIMIT_RST;
            band_low_reg  <= ghma_pkg::BAND_LOW_RST;
            band_high_reg <= ghma_pkg::BAND_HIGH_RST;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    ghma_pkg::REG_SPREAD_LIMIT: spread_reg    <= cfg_data;
                    ghma_pkg::REG_BAND_LOW:     band_low_reg  <= cfg_data;
                    ghma_pkg::REG_BAND_HIGH:    band_high_reg <= cfg_data;
                    default:                    spread_reg    <= spread_reg;
                endcase
            end
            if (cmd.accept)
            begin
                window_reg[wp_reg] <= heading;
                wp_reg             <= wp_next;
                cnt_reg            <= '0;
            end
            else if (cmd.scan)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Accumulators and output payload carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            head_reg <= heading;
            sum_reg  <= '0;
            hi_reg   <= '0;
            lo_reg   <= '1;
        end
        else if (cmd.scan)
        begin
            sum_reg <= sum_reg + ghma_pkg::SUM_W'(entry);
            if (entry > hi_reg)
            begin
                hi_reg <= entry;
            end
            if (entry < lo_reg)
            begin
                lo_reg <= entry;
            end
        end
        if (cmd.load_out)
        begin
            out_head_reg <= gate ? average : head_reg;
            out_avg_reg  <= gate;
        end
    end

    assign smoothed_heading = out_head_reg;
    assign was_averaged     = out_avg_reg;

endmodule

// ===== src/gated_heading_moving_average.sv =====
`timescale 1ns / 1ps
// Top level of the gated heading moving average.
// Depends on ghma_pkg, ghma_ctrl and ghma_datapath.

// Each accepted request carries one compass heading in whole degrees. The
// heading overwrites the oldest of eight window entries (all zero after
// reset), and the block then walks the window one entry per clock to form
// the sum, the largest and the smallest entry. When the largest entry is
// below the smallest plus spread_limit and the new heading lies within
// band_low..band_high inclusive, the result is the window sum divided by
// eight with was_averaged set; otherwise the raw heading is returned with
// was_averaged clear. Exactly one result comes out per request, in order.
// A request passes through the idle state, in which it is accepted and its
// heading written into the window, the walk over the window entries (one
// shared adder and compare pair), and the finish state, which forms the
// result and loads the output register. The next request can be accepted
// only once the block is back in the idle state, so no new request is taken
// before the previous one is through. The output register lets a new
// request be accepted while the previous result still waits for m_tready;
// if that result is still waiting when the next one is formed, the block
// holds in its last clock until m_tready takes it.
// Registers are written through cfg_wr_en, cfg_index and cfg_data; the user
// must write them only while no request is in flight, which the block does
// not enforce. Index 0 is spread_limit (reset 6), 1 is band_low (reset 10),
// 2 is band_high (reset 350); index 3 is ignored; values above 360 are used unclamped.

module gated_heading_moving_average
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,  // [8:0] heading, rest zero
    // Output stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,  // [8:0] smoothed_heading, rest zero
    output logic                           m_tuser,  // [0] was_averaged
    // Configuration write port.
    input  logic                           cfg_wr_en,
    input  logic [ghma_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ghma_pkg::HEAD_W-1:0]    cfg_data
);

    ghma_pkg::cmd_t              cmd;
    ghma_pkg::status_t           status;
    logic [ghma_pkg::HEAD_W-1:0] smoothed_heading;

    // The controller sequences one request at a time through accept,
    // window walk and result load, and owns the output valid flag.
    ghma_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the window, the accumulators, the configuration
    // registers and the output payload register.
    ghma_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .heading          (s_tdata[ghma_pkg::HEAD_W-1:0]),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .status           (status),
        .smoothed_heading (smoothed_heading),
        .was_averaged     (m_tuser)
    );

    assign m_tdata = {{(16 - ghma_pkg::HEAD_W){1'b0}}, smoothed_heading};

endmodule
